[src/dmc_pkg.sv]
`default_nettype none
package dmc_pkg;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_TARGET = 2'd1,
      FUNC_END    = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_TOKEN  = 2'd0,
      KIND_ABSENT = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_P1_RD,
      ST_P1_CHK,
      ST_DECIDE,
      ST_EMIT_TOK,
      ST_EMIT_ABS,
      ST_EMIT_END,
      ST_P2_RD,
      ST_P2_WR
   } state_type;

   typedef struct packed {
      logic     accept;
      logic     start_sweep;
      logic     mode_ext;
      logic     rd;
      logic     p1_step;
      logic     p2_step;
      logic     load_byte;
      logic     clear_all;
      logic     len_inc;
      logic     len_one;
      logic     len_zero;
      logic     set_halt;
      logic     clr_halt;
      logic     rsp_load;
      kind_type rsp_kind;
      logic     rsp_last;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     halted;
      logic     len_nz;
      logic     sweep_done;
      logic     any_ext;
      logic     any_plain;
      logic     mode_ext;
      logic     out_free;
      logic     full;
   } status_type;

endpackage
`default_nettype wire

[src/dmc_datapath.sv]
`default_nettype none
module dmc_datapath #(
   parameter int DICT_DEPTH = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dmc_pkg::cmd_type    cmd,
   output dmc_pkg::status_type      status,
   input  wire logic [1:0]          req_func,
   input  wire logic [7:0]          req_data_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_kind,
   output logic [11:0]              rsp_offset,
   output logic [12:0]              rsp_length,
   output logic                     rsp_last
);
   localparam int AW = $clog2(DICT_DEPTH);
   localparam int CW = $clog2(DICT_DEPTH + 1);

   logic [7:0] dict_mem [DICT_DEPTH];
   logic       flag_mem [DICT_DEPTH];

   logic [1:0]    func_ff;
   logic [7:0]    byte_ff;
   logic [CW-1:0] fill_ff, len_ff, idx_ff, first_ff;
   logic          halted_ff, prev_ff, any_ext_ff, any_plain_ff, found_ff, mode_ff;
   logic [7:0]    rd_dict_ff;
   logic          rd_flag_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_kind_ff;
   logic [11:0]   rsp_offset_ff;
   logic [12:0]   rsp_length_ff;
   logic          rsp_last_ff;

   logic          hit, hit_ext, flag_we, flag_wd;
   logic [AW-1:0] flag_wa;
   logic [CW:0]   end_pos, start_pos;

   assign hit     = (rd_dict_ff == byte_ff);
   assign hit_ext = hit && prev_ff;
   assign end_pos = {1'b0, first_ff} + (CW+1)'(1);
   assign start_pos = (end_pos >= {1'b0, len_ff}) ? (end_pos - {1'b0, len_ff}) : '0;

   always_comb begin
      flag_we = 1'b0;
      flag_wa = fill_ff[AW-1:0];
      flag_wd = 1'b0;
      if (cmd.load_byte) begin
         flag_we = 1'b1;
      end else if (cmd.p2_step) begin
         flag_we = 1'b1;
         flag_wa = idx_ff[AW-1:0];
         flag_wd = mode_ff ? hit_ext : hit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         dict_mem[fill_ff[AW-1:0]] <= byte_ff;
      end
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      if (cmd.rd) begin
         rd_dict_ff <= dict_mem[idx_ff[AW-1:0]];
         rd_flag_ff <= flag_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         byte_ff <= req_data_byte;
      end
      if (cmd.start_sweep) begin
         idx_ff       <= '0;
         prev_ff      <= 1'b0;
         mode_ff      <= cmd.mode_ext;
      end
      if (cmd.p1_step || cmd.p2_step) begin
         idx_ff  <= idx_ff + CW'(1);
         prev_ff <= rd_flag_ff;
      end
      if (cmd.p1_step) begin
         if (hit_ext) any_ext_ff <= 1'b1;
         if (hit) any_plain_ff <= 1'b1;
         if (rd_flag_ff && !found_ff) begin
            found_ff <= 1'b1;
            first_ff <= idx_ff;
         end
      end
      if (cmd.accept) begin
         any_ext_ff   <= 1'b0;
         any_plain_ff <= 1'b0;
         found_ff     <= 1'b0;
         first_ff     <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         len_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         if (cmd.load_byte) fill_ff <= fill_ff + CW'(1);
         if (cmd.clear_all) begin
            fill_ff   <= '0;
            len_ff    <= '0;
            halted_ff <= 1'b0;
         end
         if (cmd.len_zero)     len_ff <= '0;
         else if (cmd.len_one) len_ff <= CW'(1);
         else if (cmd.len_inc) len_ff <= len_ff + CW'(1);
         if (cmd.set_halt) halted_ff <= 1'b1;
         if (cmd.clr_halt) halted_ff <= 1'b0;
      end
   end

   // output register: holds one result until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_kind_ff <= cmd.rsp_kind;
         rsp_last_ff <= cmd.rsp_last;
         if (cmd.rsp_kind == dmc_pkg::KIND_TOKEN) begin
            rsp_offset_ff <= 12'(start_pos);
            rsp_length_ff <= 13'(len_ff);
         end else begin
            rsp_offset_ff <= '0;
            rsp_length_ff <= '0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_offset = rsp_offset_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_last   = rsp_last_ff;

   always_comb begin
      status.func       = dmc_pkg::func_type'(func_ff);
      status.halted     = halted_ff;
      status.len_nz     = (len_ff != '0);
      status.sweep_done = (idx_ff == fill_ff);
      status.any_ext    = any_ext_ff;
      status.any_plain  = any_plain_ff;
      status.mode_ext   = mode_ff;
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.full       = (fill_ff == CW'(DICT_DEPTH));
   end

endmodule
`default_nettype wire

[src/dmc_ctrl.sv]
`default_nettype none
module dmc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire dmc_pkg::status_type  status,
   output dmc_pkg::cmd_type          cmd
);
   dmc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         dmc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = dmc_pkg::ST_DISPATCH;
            end
         end
         dmc_pkg::ST_DISPATCH: begin
            unique case (status.func)
               dmc_pkg::FUNC_LOAD: begin
                  cmd.load_byte = !status.full;
                  state_in      = dmc_pkg::ST_IDLE;
               end
               dmc_pkg::FUNC_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  state_in      = dmc_pkg::ST_IDLE;
               end
               dmc_pkg::FUNC_END: begin
                  if (!status.halted && status.len_nz) begin
                     cmd.start_sweep = 1'b1;
                     state_in        = dmc_pkg::ST_P1_RD;
                  end else begin
                     state_in = dmc_pkg::ST_EMIT_END;
                  end
               end
               dmc_pkg::FUNC_TARGET: begin
                  if (status.halted) begin
                     state_in = dmc_pkg::ST_IDLE;
                  end else begin
                     cmd.start_sweep = 1'b1;
                     state_in        = dmc_pkg::ST_P1_RD;
                  end
               end
               default: state_in = dmc_pkg::ST_IDLE;
            endcase
         end
         dmc_pkg::ST_P1_RD: begin
            if (status.sweep_done) begin
               state_in = dmc_pkg::ST_DECIDE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = dmc_pkg::ST_P1_CHK;
            end
         end
         dmc_pkg::ST_P1_CHK: begin
            cmd.p1_step = 1'b1;
            state_in    = dmc_pkg::ST_P1_RD;
         end
         dmc_pkg::ST_DECIDE: begin
            priority if (status.func == dmc_pkg::FUNC_END) begin
               state_in = dmc_pkg::ST_EMIT_TOK;
            end else if (status.len_nz && status.any_ext) begin
               cmd.start_sweep = 1'b1;
               cmd.mode_ext    = 1'b1;
               state_in        = dmc_pkg::ST_P2_RD;
            end else if (status.len_nz) begin
               state_in = dmc_pkg::ST_EMIT_TOK;
            end else if (status.any_plain) begin
               cmd.start_sweep = 1'b1;
               state_in        = dmc_pkg::ST_P2_RD;
            end else begin
               state_in = dmc_pkg::ST_EMIT_ABS;
            end
         end
         dmc_pkg::ST_EMIT_TOK: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = dmc_pkg::KIND_TOKEN;
               cmd.rsp_last = (status.func == dmc_pkg::FUNC_TARGET) && status.any_plain;
               priority if (status.func == dmc_pkg::FUNC_END) begin
                  state_in = dmc_pkg::ST_EMIT_END;
               end else if (status.any_plain) begin
                  cmd.start_sweep = 1'b1;
                  state_in        = dmc_pkg::ST_P2_RD;
               end else begin
                  state_in = dmc_pkg::ST_EMIT_ABS;
               end
            end
         end
         dmc_pkg::ST_EMIT_ABS: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = dmc_pkg::KIND_ABSENT;
               cmd.rsp_last = 1'b1;
               cmd.len_zero = 1'b1;
               cmd.set_halt = 1'b1;
               state_in     = dmc_pkg::ST_IDLE;
            end
         end
         dmc_pkg::ST_EMIT_END: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = dmc_pkg::KIND_END;
               cmd.rsp_last = 1'b1;
               cmd.len_zero = 1'b1;
               cmd.clr_halt = 1'b1;
               state_in     = dmc_pkg::ST_IDLE;
            end
         end
         dmc_pkg::ST_P2_RD: begin
            if (status.sweep_done) begin
               cmd.len_inc = status.mode_ext;
               cmd.len_one = !status.mode_ext;
               state_in    = dmc_pkg::ST_IDLE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = dmc_pkg::ST_P2_WR;
            end
         end
         dmc_pkg::ST_P2_WR: begin
            cmd.p2_step = 1'b1;
            state_in    = dmc_pkg::ST_P2_RD;
         end
         default: state_in = dmc_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[src/dictionary_match_compressor.sv]
`default_nettype none
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_func, req_data_byte
// rsp     | out       | rsp_valid, rsp_ready, rsp_kind, rsp_offset, rsp_length, rsp_last
//
// Load, clear and a target byte while halted go from dispatch straight back to
// idle; an end item with no pending match goes to the end emit state. Otherwise the
// loaded dictionary (single read port) is swept once to find hits, between accept
// and decide. A target byte that keeps or starts a match sweeps again to rewrite
// match flags; each emitted result passes through its own emit state.
// Synchronous reset empties the dictionary; flags need no clearing pass.
// A stalled rsp holds the controller in its emit state; req_ready is low then.
module dictionary_match_compressor #(
   parameter int DICT_DEPTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [11:0]      rsp_offset,
   output logic [12:0]      rsp_length,
   output logic             rsp_last
);
   dmc_pkg::cmd_type    cmd;
   dmc_pkg::status_type status;

   dmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dmc_datapath #(.DICT_DEPTH(DICT_DEPTH)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_offset    (rsp_offset),
      .rsp_length    (rsp_length),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire
